[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sfr_pkg;

  localparam int WORD_BYTES      = 8;
  localparam int WORD_WIDTH      = 64;
  localparam int LEN_WIDTH       = 4;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SEARCH_WORD    = 2'd0,
    REG_SEARCH_LENGTH  = 2'd1,
    REG_REPLACE_WORD   = 2'd2,
    REG_REPLACE_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] search_word;
    logic [LEN_WIDTH-1:0]  search_length;
    logic [WORD_WIDTH-1:0] replace_word;
    logic [LEN_WIDTH-1:0]  replace_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [4:0] {
    ST_PRE   = 5'b00001,
    ST_LOOP  = 5'b00010,
    ST_REPL  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_END   = 5'b10000
  } back_state_t;

  function automatic logic [7:0] word_byte(input logic [WORD_WIDTH-1:0] w,
                                           input logic [2:0] idx);
    return w[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sfr_front.sv]
// Front stage: registers each input request and pushes it into the queue.
// Depends on sfr_pkg.
`default_nettype none

module sfr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_text,
  input  wire logic          queue_full,
  output logic               push,
  output sfr_pkg::item_t     push_item
);
  import sfr_pkg::*;

  logic  held;
  item_t held_item;

  assign push      = held && !queue_full;
  assign push_item = held_item;
  assign in_stall  = held && queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item.text_byte   <= text_byte;
      held_item.end_of_text <= end_of_text;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfr_fifo.sv]
// Short request queue between the front stage and the back sequencer.
// Depends on sfr_pkg.
`default_nettype none

module sfr_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sfr_pkg::item_t    push_item,
  output logic                   full,
  input  wire logic              pop,
  output sfr_pkg::queue_head_t   head
);
  import sfr_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] Depth = NW'(QUEUE_DEPTH);

  item_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full       = (fill == Depth);
  assign head.valid = (fill != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfr_back.sv]
// Back sequencer: holds the pending prefix, matches, replaces and flushes,
// one step per cycle unless a stalled output holds it, into a hold register and the output register.
// Depends on sfr_pkg.
`default_nettype none

module sfr_back #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sfr_pkg::cfg_t         cfg,
  input  wire sfr_pkg::queue_head_t  head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       byte_valid,
  output logic                       last
);
  import sfr_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_WIDTH-1:0] MaxLen  = LEN_WIDTH'(MAX_PATTERN);
  localparam logic [LEN_WIDTH-1:0] WordLen = LEN_WIDTH'(WORD_BYTES);

  back_state_t state;
  back_state_t state_next;

  logic [7:0]           pend [MAX_PATTERN];
  logic [CW-1:0]        cnt;
  logic                 eot_q;
  logic [LEN_WIDTH-1:0] ridx;
  logic [LEN_WIDTH-1:0] ecnt;
  logic                 hold_valid;
  logic [7:0]           hold_byte;

  logic [LEN_WIDTH-1:0] slen_full;
  logic [CW-1:0]        slen;
  logic [LEN_WIDTH-1:0] rlen;
  logic [MAX_PATTERN-1:0] pos_hit;
  logic [MAX_PATTERN-1:0] below_cnt;
  logic                 pre_ok;
  logic                 out_free;
  logic                 cap_hit;
  logic                 can_emit;
  logic                 bare_end;

  logic                 do_shift;
  logic                 do_append;
  logic                 do_match;
  logic                 do_emit;
  logic [7:0]           emit_byte;
  logic                 ridx_step;
  logic                 do_close;

  always_comb begin
    if (cfg.search_length == '0) begin
      slen_full = LEN_WIDTH'(1);
    end else if (cfg.search_length > MaxLen) begin
      slen_full = MaxLen;
    end else begin
      slen_full = cfg.search_length;
    end
    slen = slen_full[CW-1:0];
    rlen = (cfg.replace_length > WordLen) ? WordLen : cfg.replace_length;
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pos_hit[i]   = (pend[i] == word_byte(cfg.search_word, 3'(i)));
      below_cnt[i] = (CW'(i) < cnt);
    end
  end

  assign pre_ok   = &(pos_hit | ~below_cnt);
  assign out_free = !out_valid || !out_stall;
  assign cap_hit  = (ecnt == WordLen);
  assign can_emit = cap_hit || !hold_valid || out_free;
  assign bare_end = eot_q && (ecnt == '0);

  always_comb begin
    state_next = state;
    do_shift   = 1'b0;
    do_append  = 1'b0;
    do_match   = 1'b0;
    do_emit    = 1'b0;
    emit_byte  = pend[0];
    ridx_step  = 1'b0;
    do_close   = 1'b0;
    pop        = 1'b0;
    case (state)
      ST_PRE: begin
        if (head.valid) begin
          if (cnt >= slen) begin
            if (can_emit) begin
              do_shift = 1'b1;
              do_emit  = 1'b1;
            end
          end else begin
            do_append  = 1'b1;
            pop        = 1'b1;
            state_next = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (pre_ok && (cnt == slen)) begin
          do_match   = 1'b1;
          state_next = ST_REPL;
        end else if (pre_ok && (cnt < slen)) begin
          state_next = ST_FLUSH;
        end else if (can_emit) begin
          do_shift = 1'b1;
          do_emit  = 1'b1;
          if (cnt == CW'(1)) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_REPL: begin
        if (ridx < rlen) begin
          if (can_emit) begin
            do_emit   = 1'b1;
            emit_byte = word_byte(cfg.replace_word, ridx[2:0]);
            ridx_step = 1'b1;
          end
        end else begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (eot_q && (cnt != '0)) begin
          if (can_emit) begin
            do_shift = 1'b1;
            do_emit  = 1'b1;
          end
        end else begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if ((!bare_end && !hold_valid) || out_free) begin
          do_close   = 1'b1;
          state_next = ST_PRE;
        end
      end
      default: begin
        state_next = ST_PRE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PRE;
      cnt        <= '0;
      eot_q      <= 1'b0;
      ridx       <= '0;
      ecnt       <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (do_shift) begin
        cnt <= cnt - 1'b1;
      end
      if (do_append) begin
        cnt   <= cnt + 1'b1;
        eot_q <= head.item.end_of_text;
      end
      if (do_match) begin
        cnt  <= '0;
        ridx <= '0;
      end
      if (ridx_step) begin
        ridx <= ridx + 1'b1;
      end
      if (do_emit && !cap_hit) begin
        if (hold_valid) begin
          out_valid  <= 1'b1;
          out_byte   <= hold_byte;
          byte_valid <= 1'b1;
          last       <= 1'b0;
        end
        hold_byte  <= emit_byte;
        hold_valid <= 1'b1;
        ecnt       <= ecnt + 1'b1;
      end
      if (do_close) begin
        ecnt <= '0;
        if (bare_end) begin
          out_valid  <= 1'b1;
          out_byte   <= '0;
          byte_valid <= 1'b0;
          last       <= 1'b1;
        end else if (hold_valid) begin
          out_valid  <= 1'b1;
          out_byte   <= hold_byte;
          byte_valid <= 1'b1;
          last       <= eot_q;
          hold_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
    if (do_append) begin
      pend[cnt[IW-1:0]] <= head.item.text_byte;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/stream_find_and_replace.sv]
// Stream find-and-replace: one text byte per request in, rewritten bytes out.
// An accepted byte passes the front register, the queue, the back sequencer's hold register and the output register.
// New bytes are accepted while earlier ones are still in the back sequencer, until the queue fills.
// Reset (rst, synchronous): empties queue, pending bytes and outputs, and
// returns the registers to search length 1 and all else zero.
`default_nettype none

module stream_find_and_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [sfr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [sfr_pkg::WORD_WIDTH-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           text_byte,
  input  wire logic                                 end_of_text,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [7:0]                                out_byte,
  output logic                                      byte_valid,
  output logic                                      last
);
  import sfr_pkg::*;

  cfg_t        cfg;
  logic        queue_full;
  logic        push;
  item_t       push_item;
  logic        pop;
  queue_head_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.search_word    <= '0;
      cfg.search_length  <= LEN_WIDTH'(1);
      cfg.replace_word   <= '0;
      cfg.replace_length <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEARCH_WORD:    cfg.search_word    <= cfg_data;
        REG_SEARCH_LENGTH:  cfg.search_length  <= cfg_data[LEN_WIDTH-1:0];
        REG_REPLACE_WORD:   cfg.replace_word   <= cfg_data;
        REG_REPLACE_LENGTH: cfg.replace_length <= cfg_data[LEN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  sfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  sfr_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last)
  );

endmodule

`default_nettype wire

[hw/rtl/sfr_checker.sv]
// Port-level checks for the stream find-and-replace block, bound to its top.
// Depends only on the top level's ports.
`default_nettype none

module sfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       last
);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("bare end marker without last");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(last))
    else $error("stalled result changed");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .last       (last)
);

`default_nettype wire

[dv/stream_find_and_replace_tb.sv]
`timescale 1ns / 100ps
// Testbench for stream_find_and_replace. It runs a directed table, then random texts built
// from pieces of the search word, and checks every result against a byte-level predictor.
// Depends on sfr_pkg and the stream_find_and_replace RTL.

module stream_find_and_replace_tb;
  import sfr_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 400;
  localparam int CALM_ITEMS   = 60;
  localparam int PATTERN_MAX  = 8;
  localparam int MAX_RESULTS  = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       is_last;
  } rewrite_t;

  typedef struct packed {
    logic        is_setting;
    logic [63:0] sw;
    logic [63:0] sl;
    logic [63:0] rw;
    logic [63:0] rl;
    logic [7:0]  ch;
    logic        eot;
    logic        typed;
    rewrite_t    res;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [WORD_WIDTH-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            text_byte;
  logic                  end_of_text;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_byte;
  logic                  byte_valid;
  logic                  last;

  logic [WORD_WIDTH-1:0] find_word = '0;
  logic [WORD_WIDTH-1:0] subst_word = '0;
  logic [LEN_WIDTH-1:0]  find_len = 4'd1;
  logic [LEN_WIDTH-1:0]  subst_len = '0;
  logic [7:0]            held [0:PATTERN_MAX-1];
  int unsigned           held_count = 0;
  rewrite_t              step_q[$];
  rewrite_t              rewritten_q[$];
  plan_row_t             plan_q[$];
  int unsigned           error_count = 0;
  bit                    calm = 1'b0;

  stream_find_and_replace uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last        (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
  endtask

  function automatic int unsigned find_span();
    if (find_len == 0) return 1;
    if (find_len > PATTERN_MAX) return PATTERN_MAX;
    return find_len;
  endfunction

  function automatic bit held_is_prefix(int unsigned cnt);
    int unsigned i;
    for (i = 0; i < cnt; i++)
      if (held[i] != find_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void emit(rewrite_t r);
    if (step_q.size() < MAX_RESULTS) step_q.push_back(r);
  endfunction

  function automatic void pass_oldest();
    int unsigned i;
    emit({held[0], 1'b1, 1'b0});
    for (i = 1; i < held_count; i++) held[i-1] = held[i];
    held_count--;
  endfunction

  function automatic void predict_rewrite(logic [7:0] ch, logic eot);
    int unsigned span;
    int unsigned subst_span;
    int unsigned i;
    span = find_span();
    subst_span = (subst_len > MAX_RESULTS) ? MAX_RESULTS : subst_len;
    step_q.delete();
    while (held_count >= span && held_count > 0) pass_oldest();
    held[held_count] = ch;
    held_count++;
    while (held_count > 0) begin
      if (held_count == span && held_is_prefix(span)) begin
        for (i = 0; i < subst_span; i++) emit({subst_word[8*i +: 8], 1'b1, 1'b0});
        held_count = 0;
        break;
      end
      if (held_count < span && held_is_prefix(held_count)) break;
      pass_oldest();
    end
    if (eot) begin
      while (held_count > 0) pass_oldest();
      if (step_q.size() == 0) emit('0);
      step_q[step_q.size()-1].is_last = 1'b1;
      for (i = 0; i < PATTERN_MAX; i++) held[i] = 8'h00;
    end
  endfunction

  function automatic logic [63:0] random_length(int unsigned lo);
    logic [63:0] v;
    int unsigned pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 7) v[3:0] = 4'($urandom_range(lo, 8));
    else if (pick == 7) v[3:0] = 4'd0;
    else v[3:0] = 4'($urandom_range(9, 15));
    return v;
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] v;
    int unsigned pick;
    int unsigned i;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    for (i = 0; i < 8; i++)
      v[8*i +: 8] = (pick < 8) ? 8'(8'h61 + $urandom_range(0, 1)) :
                                 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic void add_setting(logic [63:0] sw, logic [63:0] sl, logic [63:0] rw,
                                      logic [63:0] rl);
    plan_row_t row;
    row = '0;
    row.is_setting = 1'b1;
    row.sw = sw;
    row.sl = sl;
    row.rw = rw;
    row.rl = rl;
    plan_q.push_back(row);
  endfunction

  function automatic void add_text(logic [7:0] ch, logic eot, logic typed, rewrite_t res);
    plan_row_t row;
    row = '0;
    row.ch = ch;
    row.eot = eot;
    row.typed = typed;
    row.res = res;
    plan_q.push_back(row);
  endfunction

  task automatic send_request(logic [7:0] ch, logic eot, logic typed, rewrite_t res);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_rewrite(ch, eot);
    if (typed) rewritten_q.push_back(res);
    else foreach (step_q[i]) rewritten_q.push_back(step_q[i]);
  endtask

  task automatic write_register(cfg_reg_t r, logic [63:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    case (r)
      REG_SEARCH_WORD:    find_word = v;
      REG_SEARCH_LENGTH:  find_len = v[LEN_WIDTH-1:0];
      REG_REPLACE_WORD:   subst_word = v;
      REG_REPLACE_LENGTH: subst_len = v[LEN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [63:0] sw, logic [63:0] sl, logic [63:0] rw,
                                logic [63:0] rl);
    // hold off until the block has drained
    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_register(REG_SEARCH_WORD, sw);
    write_register(REG_SEARCH_LENGTH, sl);
    write_register(REG_REPLACE_WORD, rw);
    write_register(REG_REPLACE_LENGTH, rl);
    cfg_write <= 1'b0;
  endtask

  task automatic check_result();
    rewrite_t want;
    if (rewritten_q.size() == 0) begin
      report_mismatch("unexpected result, out_byte", 8'h00, out_byte);
      return;
    end
    want = rewritten_q.pop_front();
    if (out_byte !== want.ch) report_mismatch("out_byte", want.ch, out_byte);
    if (byte_valid !== want.has_char)
      report_mismatch("byte_valid", 8'(want.has_char), 8'(byte_valid));
    if (last !== want.is_last) report_mismatch("last", 8'(want.is_last), 8'(last));
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    plan_row_t   row;
    logic [7:0]  text_q[$];
    int unsigned sent;
    int unsigned phase_len;
    int unsigned span;
    int unsigned piece;
    int unsigned cut;
    int unsigned i;
    for (i = 0; i < PATTERN_MAX; i++) held[i] = 8'h00;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_SEARCH_WORD;
    cfg_data <= '0;
    in_valid <= 1'b0;
    text_byte <= 8'h00;
    end_of_text <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: single zero byte deleted
    add_text(8'h41, 1'b1, 1'b1, {8'h41, 1'b1, 1'b1});
    add_text(8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1});
    add_text(8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1});
    add_setting(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    add_text(8'h61, 1'b0, 1'b0, '0);
    add_text(8'h62, 1'b0, 1'b0, '0);
    add_text(8'h61, 1'b0, 1'b0, '0);
    add_text(8'h61, 1'b0, 1'b0, '0);
    add_text(8'h62, 1'b1, 1'b0, '0);
    add_text(8'h61, 1'b1, 1'b1, {8'h61, 1'b1, 1'b1});
    // zero search length and oversized replacement length
    add_setting(64'hFFFF_FFFF_FFFF_FF7A, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8877_6655_4433_2211,
                64'h0000_0000_0000_000F);
    add_text(8'h7A, 1'b1, 1'b0, '0);
    add_text(8'h00, 1'b1, 1'b1, {8'h00, 1'b1, 1'b1});
    // oversized search length, all-ones word
    add_setting('1, 64'd9, '0, 64'd8);
    for (i = 0; i < 10; i++) add_text(8'hFF, 1'b0, 1'b0, '0);
    add_text(8'h00, 1'b1, 1'b0, '0);
    // shrink the search length while bytes are held
    add_setting(64'h0807_0605_0403_0201, 64'd8, 64'h41, 64'd1);
    add_text(8'h01, 1'b0, 1'b0, '0);
    add_text(8'h02, 1'b0, 1'b0, '0);
    add_text(8'h03, 1'b0, 1'b0, '0);
    add_setting(64'h0807_0605_0403_0201, 64'd2, '0, 64'd0);
    add_text(8'h01, 1'b1, 1'b0, '0);

    foreach (plan_q[k]) begin
      row = plan_q[k];
      if (row.is_setting) apply_settings(row.sw, row.sl, row.rw, row.rl);
      else send_request(row.ch, row.eot, row.typed, row.res);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_settings(random_word(), random_length(1), random_word(), random_length(0));
      span = find_span();
      phase_len = $urandom_range(20, 45);
      text_q.delete();
      while (text_q.size() < phase_len) begin
        piece = $urandom_range(0, 9);
        if (piece < 4) begin
          for (i = 0; i < span; i++) text_q.push_back(find_word[8*i +: 8]);
        end else if (piece < 6) begin
          cut = $urandom_range(1, span);
          for (i = 0; i < cut; i++) text_q.push_back(find_word[8*i +: 8]);
          text_q.push_back(8'($urandom_range(0, 255)));
        end else if (piece < 9) begin
          text_q.push_back(8'(8'h61 + $urandom_range(0, 1)));
        end else begin
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (text_q[k]) begin
        calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
        send_request(text_q[k], $urandom_range(0, 11) == 0, 1'b0, '0);
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_fifo.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_and_replace.sv
hw/rtl/sfr_checker.sv
dv/stream_find_and_replace_tb.sv
